@@ design/nhdlc_pkg.sv @@
// Shared types and constants for the NRZI HDLC bit deframer.
`default_nettype none
package nhdlc_pkg;

  localparam int COUNT_W = 10;

  localparam logic [COUNT_W-1:0] MAX_FRAME_BYTES = 10'd512;
  localparam logic [COUNT_W-1:0] MIN_FRAME_RESET = 10'd17;

  localparam logic [7:0]  FLAG_PATTERN  = 8'h7E;
  localparam logic [7:0]  ABORT_PATTERN = 8'hFE;
  localparam logic [3:0]  STUFF_RUN     = 4'd5;
  localparam logic [3:0]  RUN_SAT       = 4'd15;
  localparam logic [3:0]  BITS_PER_BYTE = 4'd8;
  localparam logic [15:0] FCS_PRESET    = 16'hFFFF;
  localparam logic [15:0] FCS_POLY      = 16'h8408;
  localparam logic [15:0] FCS_GOOD      = 16'hF0B8;

  typedef enum logic [1:0] {
    EV_DATA   = 2'd0,
    EV_GOOD   = 2'd1,
    EV_REJECT = 2'd2,
    EV_ABORT  = 2'd3
  } event_t;

  typedef struct packed {
    logic               valid;
    event_t             kind;
    logic [7:0]         data;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage
`default_nettype wire

@@ design/nrzi_hdlc_bit_deframer.sv @@
// Top level of the NRZI HDLC bit deframer: input register, core, result register.
//
// Usage: one recovered line level per transfer on the input channel (line_bit).
// Each transfer yields zero or one result on the output channel: a data byte
// (event_kind 0) or an end-of-frame report (good, rejected, aborted) with the
// frame byte count in frame_bytes.
// min_frame_bytes is written through the cfg channel; cfg_ready is always high.
// Write it only while no transfer is in flight on either channel.
// A transferred bit waits in the input register, is decoded by the core when the
// result register can advance, and its result is presented until transferred out.
// Throughput: one bit per cycle while out_ready does not stall the result register,
// set by the combinational bit update and the byte-wide FCS update in the core.
// Stall: while a result waits with out_ready low, the result register holds and
// the input register holds its bit; in_ready drops only when both are full.
// Reset (rst, synchronous): clears the deframer state to idle, presets the FCS,
// empties both registers and restores min_frame_bytes to 17.
`default_nettype none
module nrzi_hdlc_bit_deframer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          line_bit,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         event_kind,
  output logic [7:0]                         data_byte,
  output logic [nhdlc_pkg::COUNT_W-1:0]      frame_bytes,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [nhdlc_pkg::COUNT_W-1:0] min_frame_bytes
);

  logic                          s1_valid;
  logic                          s1_bit;
  logic                          advance;
  logic                          step;
  logic [nhdlc_pkg::COUNT_W-1:0] min_frame;
  nhdlc_pkg::result_t            result;

  assign advance   = !out_valid || out_ready;
  assign in_ready  = !s1_valid || advance;
  assign step      = s1_valid && advance;
  assign cfg_ready = 1'b1;

  nhdlc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .level     (s1_bit),
    .min_frame (min_frame),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_frame <= nhdlc_pkg::MIN_FRAME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_frame <= min_frame_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready) begin
      s1_bit <= line_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && result.valid;
    end
    if (step && result.valid) begin
      event_kind  <= result.kind;
      data_byte   <= result.data;
      frame_bytes <= result.count;
    end
  end

`ifndef SYNTH
  a_hold_bit: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_bit))
    else $error("input register lost a held bit");

  a_data_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == nhdlc_pkg::EV_DATA |-> frame_bytes != '0)
    else $error("data byte with zero frame count");

  a_end_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != nhdlc_pkg::EV_DATA |-> data_byte == 8'd0)
    else $error("frame report carries data");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frame_bytes <= nhdlc_pkg::MAX_FRAME_BYTES && frame_bytes != '0)
    else $error("frame count out of range");
`endif

endmodule
`default_nettype wire

@@ design/nhdlc_fcs.sv @@
// Byte-wide AX.25 frame check sequence update (reflected CRC-16).
`default_nettype none
module nhdlc_fcs (
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  data_in,
  output logic      [15:0] crc_out
);

  always_comb begin
    logic [15:0] crc;
    logic [7:0]  d;
    crc = crc_in;
    d   = data_in;
    for (int i = 0; i < 8; i++) begin
      if (crc[0] ^ d[0]) begin
        crc = (crc >> 1) ^ nhdlc_pkg::FCS_POLY;
      end else begin
        crc = crc >> 1;
      end
      d = d >> 1;
    end
    crc_out = crc;
  end

endmodule
`default_nettype wire

@@ design/nhdlc_core.sv @@
// Per-bit NRZI decode, destuffing, flag and abort detection, byte assembly and FCS check.
`default_nettype none
module nhdlc_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           step,
  input  wire logic                           level,
  input  wire logic [nhdlc_pkg::COUNT_W-1:0]  min_frame,
  output nhdlc_pkg::result_t                  result
);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_SYNC    = 2'd1,
    PH_RECEIVE = 2'd2
  } phase_t;

  logic                          previous_level, previous_level_next;
  logic [3:0]                    ones_run, ones_run_next;
  logic                          flag_pending, flag_pending_next;
  logic [7:0]                    shift_byte, shift_byte_next;
  logic [3:0]                    bit_count, bit_count_next;
  phase_t                        frame_phase, frame_phase_next;
  logic [nhdlc_pkg::COUNT_W-1:0] byte_count, byte_count_next;
  logic [15:0]                   fcs_register, fcs_register_next;
  logic [15:0]                   fcs_updated;

  logic       b;
  logic       pending;
  logic [7:0] sb;
  logic [3:0] bc;

  assign b  = (level == previous_level);
  assign sb = {b, shift_byte[7:1]};

  nhdlc_fcs u_fcs (
    .crc_in  (fcs_register),
    .data_in (sb),
    .crc_out (fcs_updated)
  );

  always_comb begin
    previous_level_next = level;
    ones_run_next       = ones_run;
    flag_pending_next   = flag_pending;
    shift_byte_next     = shift_byte;
    bit_count_next      = bit_count;
    frame_phase_next    = frame_phase;
    byte_count_next     = byte_count;
    fcs_register_next   = fcs_register;
    result              = '0;
    pending             = (ones_run == nhdlc_pkg::STUFF_RUN) ? b : flag_pending;
    bc                  = (bit_count != nhdlc_pkg::RUN_SAT) ? bit_count + 4'd1 : bit_count;

    if (ones_run == nhdlc_pkg::STUFF_RUN && !b) begin
      flag_pending_next = 1'b0;
      ones_run_next     = 4'd0;
    end else begin
      shift_byte_next   = sb;
      bit_count_next    = bc;
      flag_pending_next = pending;
      if (b) begin
        ones_run_next = (ones_run != nhdlc_pkg::RUN_SAT) ? ones_run + 4'd1 : ones_run;
      end else begin
        ones_run_next = 4'd0;
      end
      if (pending) begin
        if (sb == nhdlc_pkg::FLAG_PATTERN || sb == nhdlc_pkg::ABORT_PATTERN) begin
          frame_phase_next  = (sb == nhdlc_pkg::FLAG_PATTERN) ? PH_SYNC : PH_IDLE;
          flag_pending_next = 1'b0;
          bit_count_next    = 4'd0;
          byte_count_next   = '0;
          fcs_register_next = nhdlc_pkg::FCS_PRESET;
          result.valid      = (byte_count != '0);
          result.count      = byte_count;
          if (sb == nhdlc_pkg::ABORT_PATTERN) begin
            result.kind = nhdlc_pkg::EV_ABORT;
          end else if (byte_count >= min_frame && fcs_register == nhdlc_pkg::FCS_GOOD) begin
            result.kind = nhdlc_pkg::EV_GOOD;
          end else begin
            result.kind = nhdlc_pkg::EV_REJECT;
          end
        end
      end else if ((frame_phase == PH_SYNC || frame_phase == PH_RECEIVE) &&
                   bc == nhdlc_pkg::BITS_PER_BYTE) begin
        frame_phase_next = PH_RECEIVE;
        bit_count_next   = 4'd0;
        if (byte_count < nhdlc_pkg::MAX_FRAME_BYTES) begin
          byte_count_next   = byte_count + 1'b1;
          fcs_register_next = fcs_updated;
          result.valid      = 1'b1;
          result.kind       = nhdlc_pkg::EV_DATA;
          result.data       = sb;
          result.count      = byte_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level <= 1'b0;
      ones_run       <= 4'd0;
      flag_pending   <= 1'b0;
      shift_byte     <= 8'd0;
      bit_count      <= 4'd0;
      frame_phase    <= PH_IDLE;
      byte_count     <= '0;
      fcs_register   <= nhdlc_pkg::FCS_PRESET;
    end else if (step) begin
      previous_level <= previous_level_next;
      ones_run       <= ones_run_next;
      flag_pending   <= flag_pending_next;
      shift_byte     <= shift_byte_next;
      bit_count      <= bit_count_next;
      frame_phase    <= frame_phase_next;
      byte_count     <= byte_count_next;
      fcs_register   <= fcs_register_next;
    end
  end

endmodule
`default_nettype wire

@@ test/nrzi_hdlc_bit_deframer_tb.sv @@
`timescale 1ns / 1ps
// Testbench for the NRZI HDLC bit deframer: framed and random line traffic.
module nrzi_hdlc_bit_deframer_tb;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_BITS   = 400;
  localparam int PRINT_LIMIT   = 40;

  typedef enum logic [1:0] {PH_IDLE, PH_SYNC, PH_RECV} phase_t;
  typedef enum logic [1:0] {STALL_NONE, STALL_MASK, STALL_COIN} stall_mode_t;
  typedef enum logic [1:0] {CHECK_RIGHT, CHECK_WRONG, CHECK_NONE} check_mode_t;
  typedef enum logic [1:0] {END_FLAG, END_ABORT, END_OPEN} frame_end_t;

  typedef struct packed {
    nhdlc_pkg::event_t                kind;
    logic [7:0]                       data;
    logic [nhdlc_pkg::COUNT_W-1:0]    count;
  } frame_event_t;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          line_bit = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [1:0]                    event_kind;
  logic [7:0]                    data_byte;
  logic [nhdlc_pkg::COUNT_W-1:0] frame_bytes;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [nhdlc_pkg::COUNT_W-1:0] min_frame_bytes = nhdlc_pkg::MIN_FRAME_RESET;

  nrzi_hdlc_bit_deframer i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .line_bit        (line_bit),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .event_kind      (event_kind),
    .data_byte       (data_byte),
    .frame_bytes     (frame_bytes),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .min_frame_bytes (min_frame_bytes)
  );

  logic                          rx_prev_level = 1'b0;
  logic [3:0]                    rx_ones = 4'd0;
  logic                          rx_flag_pending = 1'b0;
  logic [7:0]                    rx_shift = 8'd0;
  logic [3:0]                    rx_bits = 4'd0;
  phase_t                        rx_phase = PH_IDLE;
  logic [nhdlc_pkg::COUNT_W-1:0] rx_bytes = '0;
  logic [15:0]                   rx_fcs = nhdlc_pkg::FCS_PRESET;
  logic [nhdlc_pkg::COUNT_W-1:0] rx_min_len = nhdlc_pkg::MIN_FRAME_RESET;

  frame_event_t due_events[$];
  logic [7:0]   payload[$];

  int          error_count = 0;
  int          bits_sent = 0;
  int          burst_left = 0;
  logic        tx_level = 1'b0;
  int          tx_ones = 0;
  stall_mode_t stall_mode = STALL_NONE;
  logic [15:0] stall_mask = 16'hFFFF;
  logic [3:0]  stall_step = 4'd0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [15:0] fcs_next(input logic [15:0] crc, input logic [7:0] octet);
    logic [15:0] c;
    int          i;
    c = crc;
    for (i = 0; i < 8; i++) begin
      if (c[0] ^ octet[i]) c = (c >> 1) ^ nhdlc_pkg::FCS_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  function automatic void decode_level(input logic level);
    logic                          one;
    logic                          accept;
    logic [nhdlc_pkg::COUNT_W-1:0] count;
    one = (level == rx_prev_level);
    rx_prev_level = level;
    if (rx_ones == nhdlc_pkg::STUFF_RUN) begin
      if (one) begin
        rx_flag_pending = 1'b1;
      end else begin
        rx_flag_pending = 1'b0;
        rx_ones = 4'd0;
        return;
      end
    end
    rx_shift = {one, rx_shift[7:1]};
    if (rx_bits != nhdlc_pkg::RUN_SAT) rx_bits++;
    if (!one) rx_ones = 4'd0;
    else if (rx_ones != nhdlc_pkg::RUN_SAT) rx_ones++;
    if (rx_flag_pending) begin
      if (rx_shift == nhdlc_pkg::FLAG_PATTERN || rx_shift == nhdlc_pkg::ABORT_PATTERN) begin
        count = rx_bytes;
        accept = (count >= rx_min_len) && (rx_fcs == nhdlc_pkg::FCS_GOOD);
        rx_phase = (rx_shift == nhdlc_pkg::FLAG_PATTERN) ? PH_SYNC : PH_IDLE;
        rx_flag_pending = 1'b0;
        rx_bits = 4'd0;
        rx_bytes = '0;
        rx_fcs = nhdlc_pkg::FCS_PRESET;
        if (count != '0) begin
          if (rx_shift == nhdlc_pkg::ABORT_PATTERN)
            due_events.push_back(frame_event_t'({nhdlc_pkg::EV_ABORT, 8'd0, count}));
          else if (accept)
            due_events.push_back(frame_event_t'({nhdlc_pkg::EV_GOOD, 8'd0, count}));
          else
            due_events.push_back(frame_event_t'({nhdlc_pkg::EV_REJECT, 8'd0, count}));
        end
      end
      return;
    end
    if (rx_phase != PH_IDLE && rx_bits == nhdlc_pkg::BITS_PER_BYTE) begin
      rx_phase = PH_RECV;
      rx_bits = 4'd0;
      if (rx_bytes < nhdlc_pkg::MAX_FRAME_BYTES) begin
        rx_bytes++;
        rx_fcs = fcs_next(rx_fcs, rx_shift);
        due_events.push_back(frame_event_t'({nhdlc_pkg::EV_DATA, rx_shift, rx_bytes}));
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin : check_results
    frame_event_t want;
    if (!rst) begin
      if (in_valid && in_ready) decode_level(line_bit);
      if (cfg_valid && cfg_ready) rx_min_len = min_frame_bytes;
      if (out_valid && out_ready) begin
        if (due_events.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d byte %02h count %0d",
                                    event_kind, data_byte, frame_bytes));
        end else begin
          want = due_events.pop_front();
          if (event_kind != want.kind)
            report_mismatch($sformatf("event_kind %0d, want %0d", event_kind, want.kind));
          if (data_byte != want.data)
            report_mismatch($sformatf("data_byte %02h, want %02h", data_byte, want.data));
          if (frame_bytes != want.count)
            report_mismatch($sformatf("frame_bytes %0d, want %0d", frame_bytes, want.count));
        end
      end
    end
  end

  always @(posedge clk) begin
    stall_step <= stall_step + 4'd1;
    if (stall_step == 4'd15) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 2));
      stall_mask <= 16'($urandom) | 16'h0001;
    end
    case (stall_mode)
      STALL_NONE: out_ready <= 1'b1;
      STALL_MASK: out_ready <= stall_mask[stall_step];
      default:    out_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic send_level(input logic level);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    line_bit <= level;
    tx_level = level;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    bits_sent++;
  endtask

  task automatic send_bit(input logic one);
    send_level(one ? tx_level : ~tx_level);
  endtask

  task automatic send_octet(input logic [7:0] octet, input logic stuffed);
    int i;
    for (i = 0; i < 8; i++) begin
      send_bit(octet[i]);
      if (!stuffed || !octet[i]) begin
        tx_ones = 0;
      end else begin
        tx_ones++;
        if (tx_ones == 5) begin
          send_bit(1'b0);
          tx_ones = 0;
        end
      end
    end
  endtask

  task automatic send_frame(input check_mode_t check_mode, input frame_end_t ending);
    logic [15:0] crc;
    int          i;
    crc = nhdlc_pkg::FCS_PRESET;
    send_octet(nhdlc_pkg::FLAG_PATTERN, 1'b0);
    for (i = 0; i < payload.size(); i++) begin
      crc = fcs_next(crc, payload[i]);
      send_octet(payload[i], 1'b1);
    end
    if (ending == END_ABORT) begin
      send_octet(nhdlc_pkg::ABORT_PATTERN, 1'b0);
      repeat ($urandom_range(0, 12)) send_bit(1'b1);
    end else begin
      crc = ~crc;
      if (check_mode == CHECK_WRONG) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      if (check_mode != CHECK_NONE) begin
        send_octet(crc[7:0], 1'b1);
        send_octet(crc[15:8], 1'b1);
      end
      if (ending == END_FLAG) send_octet(nhdlc_pkg::FLAG_PATTERN, 1'b0);
    end
  endtask

  task automatic fill_payload(input int len);
    int r;
    payload.delete();
    repeat (len) begin
      r = $urandom_range(0, 7);
      if (r == 0) payload.push_back(8'hFF);
      else if (r == 1) payload.push_back(nhdlc_pkg::FLAG_PATTERN);
      else payload.push_back(8'($urandom));
    end
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_min_len(input logic [nhdlc_pkg::COUNT_W-1:0] len);
    wait_results_drained();
    cfg_valid <= 1'b1;
    min_frame_bytes <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_idle_line();
    repeat (20) send_bit(1'b1);
    repeat (12) send_bit(1'b0);
    send_octet(nhdlc_pkg::FLAG_PATTERN, 1'b0);
    send_octet(nhdlc_pkg::FLAG_PATTERN, 1'b0);
    send_octet(nhdlc_pkg::ABORT_PATTERN, 1'b0);
    send_octet(nhdlc_pkg::FLAG_PATTERN, 1'b0);
  endtask

  task automatic test_default_min();
    fill_payload(15);
    send_frame(CHECK_RIGHT, END_FLAG);
    fill_payload(14);
    send_frame(CHECK_RIGHT, END_FLAG);
  endtask

  task automatic test_stuffing();
    write_min_len(10'd1);
    payload = '{8'hFF, 8'h7E, 8'hFE, 8'h00, 8'h3F, 8'hFC, 8'hFF, 8'hFF};
    send_frame(CHECK_RIGHT, END_FLAG);
    payload.delete();
    send_frame(CHECK_RIGHT, END_FLAG);
  endtask

  task automatic test_check_errors();
    fill_payload(6);
    send_frame(CHECK_WRONG, END_FLAG);
    fill_payload(3);
    send_frame(CHECK_NONE, END_FLAG);
  endtask

  task automatic test_aborts();
    fill_payload(4);
    send_frame(CHECK_RIGHT, END_ABORT);
    repeat (20) send_bit(1'b1);
    send_octet(nhdlc_pkg::FLAG_PATTERN, 1'b0);
    send_octet(nhdlc_pkg::ABORT_PATTERN, 1'b0);
  endtask

  task automatic test_line_noise();
    fill_payload(3);
    send_frame(CHECK_RIGHT, END_OPEN);
    repeat (40) send_level(1'($urandom));
    send_octet(nhdlc_pkg::FLAG_PATTERN, 1'b0);
  endtask

  task automatic test_min_extremes();
    write_min_len(10'd0);
    payload = '{8'h5A};
    send_frame(CHECK_NONE, END_FLAG);
    payload.delete();
    send_frame(CHECK_RIGHT, END_FLAG);
    write_min_len(10'd1023);
    fill_payload(8);
    send_frame(CHECK_RIGHT, END_FLAG);
    write_min_len(nhdlc_pkg::MAX_FRAME_BYTES);
    fill_payload(20);
    send_frame(CHECK_RIGHT, END_FLAG);
  endtask

  task automatic test_random_traffic();
    int start;
    int pick;
    start = bits_sent;
    write_min_len(10'd4);
    while (bits_sent - start < RANDOM_BITS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        if ($urandom_range(0, 4) == 0) write_min_len(10'($urandom));
        else write_min_len(10'($urandom_range(1, 20)));
      end else if (pick < 3) begin
        repeat ($urandom_range(1, 30)) send_level(1'($urandom));
      end else begin
        repeat ($urandom_range(0, 2)) send_octet(nhdlc_pkg::FLAG_PATTERN, 1'b0);
        fill_payload(($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(0, 16));
        send_frame(($urandom_range(0, 3) == 0) ? CHECK_WRONG : CHECK_RIGHT,
                   (pick == 3) ? END_ABORT : (pick == 4) ? END_OPEN : END_FLAG);
      end
    end
    send_octet(nhdlc_pkg::FLAG_PATTERN, 1'b0);
  endtask

  initial begin : run_tests
    int settle;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_line();
    test_default_min();
    test_stuffing();
    test_check_errors();
    test_aborts();
    test_line_noise();
    test_min_extremes();
    test_random_traffic();
    in_valid <= 1'b0;
    settle = 0;
    while (due_events.size() != 0 && settle < 5000) begin
      @(posedge clk);
      settle++;
    end
    if (due_events.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_events.size()));
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
